[rtl/picn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picn_pkg
// Shared types and constants for the planar image to pixel index decoder.
// ----------------------------------------------------------------------------
package picn_pkg;

  // default limits on the decoded image size
  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 400;

  // header length in bytes: width-1, height-1, two unused bytes
  localparam int HEADER_LEN = 6;

  // fixed result field widths
  localparam int KIND_W   = 2;
  localparam int GROUP_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int IMG_W_W  = 10;
  localparam int IMG_H_W  = 9;

  // packed output tdata width, rounded up to whole bytes
  localparam int OUT_FIELDS_W = GROUP_W + COUNT_W + IMG_W_W + IMG_H_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PIXELS = 2'd0,
    KIND_DIMS   = 2'd1,
    KIND_ERROR  = 2'd2
  } result_kind_t;

  // parse phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } parse_phase_t;

  // the four plane bytes of one column
  typedef struct packed {
    logic [7:0] intens;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } planes_t;

endpackage

[rtl/picn_expand.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picn_expand
// Planar to chunky conversion of one column: eight 4-bit indices, leftmost
// pixel from bit 7 of each plane, placed in the top nibble.
// ----------------------------------------------------------------------------
module picn_expand
  import picn_pkg::*;
(
  input  planes_t              planes,
  input  logic [COUNT_W-1:0]   count,
  output logic [GROUP_W-1:0]   group
);

  // nibbles at or beyond the count stay zero
  always_comb begin
    group = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < count) begin
        group[GROUP_W-1-4*k -: 4] = {planes.intens[7-k], planes.red[7-k],
                                     planes.green[7-k], planes.blue[7-k]};
      end
    end
  end

endmodule

[rtl/planar_icn_to_pixel_index_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_icn_to_pixel_index_top
// Four-plane planar image file decoder producing packed 4-bit pixel indices.
// ----------------------------------------------------------------------------
// Input stream: one file byte per transfer. in_tuser flags the first byte of
// a file, which restarts the parse; file_size is sampled with that byte.
// The 6-byte header gives width-1 and height-1 (little endian). At its last
// byte one result is sent: dimensions, or an error after which bytes are
// dropped until the next file start. Blue, green and red bytes of a row are
// kept in three row buffers; each intensity byte produces one pixel group.
// Bytes that produce no result are absorbed without an output transfer.
// Throughput: one byte per cycle unless the output stalls. Latency: a result
// appears on the output register the cycle after its byte is taken. The row
// buffer read for a group is done at the accepting edge, so only the output
// register sits between a byte and its result.
// Stalls: while out_tvalid is high and out_tready low, in_tready drops; no
// transfer is lost. Reset clears the parse state and the output valid; the
// row buffers need no clearing, each column is written before it is read.
// ----------------------------------------------------------------------------
module planar_icn_to_pixel_index_top
  import picn_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [31:0]             in_tdata,   // [7:0] data_byte, [31:8] file_size
  input  logic                    in_tuser,   // [0] start_of_file
  // result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // [31:0] pixel_group, [35:32] pixel_count,
                                              // [45:36] image_width, [54:46] image_height
  output logic [KIND_W-1:0]       out_tuser,  // [1:0] result_kind
  output logic                    out_tlast   // last_of_image
);

  localparam int RB_MAX = (MAX_WIDTH + 7) / 8;
  localparam int RB_AW  = (RB_MAX > 1) ? $clog2(RB_MAX) : 1;
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);

  // parse state
  parse_phase_t     phase_r, phase_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [H_W-1:0]   h_r, h_nxt;
  logic [23:0]      size_r, size_nxt;
  logic [H_W-1:0]   row_r, row_nxt;
  logic [1:0]       plane_r, plane_nxt;
  logic [RB_AW-1:0] col_r, col_nxt;
  logic             bad_r, bad_nxt;

  // row buffers, one per color plane
  logic [7:0] blue_mem  [RB_MAX];
  logic [7:0] green_mem [RB_MAX];
  logic [7:0] red_mem   [RB_MAX];

  // output register
  logic               out_valid_r, out_valid_nxt;
  result_kind_t       kind_r, kind_nxt;
  planes_t            planes_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IMG_W_W-1:0] wout_r, wout_nxt;
  logic [IMG_H_W-1:0] hout_r, hout_nxt;
  logic               last_r, last_nxt;

  // decode
  logic         in_xfer;
  logic [7:0]   in_byte;
  logic         sof;
  parse_phase_t phase_eff;
  logic [2:0]   pos_eff;
  logic         bad_eff;
  logic [23:0]  size_eff;
  logic [15:0]  raw;
  logic [16:0]  raw_p1;
  logic [15:0]  rb16;
  logic [31:0]  need32;
  logic         hdr_end, hdr_fail;
  logic         pix_act, pix_store, pix_emit;
  logic [15:0]  col_p1_16;
  logic         col_wrap;
  logic [15:0]  row_p1_16;
  logic         row_end;
  logic [15:0]  left16;
  logic [31:0]  w_ext, h_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_byte   = in_tdata[7:0];
  assign sof       = in_tuser;

  // shared decode of the current byte
  always_comb begin
    phase_eff = sof ? PH_HEADER : phase_r;
    pos_eff   = sof ? 3'd0 : pos_r;
    bad_eff   = sof ? 1'b0 : bad_r;
    size_eff  = sof ? in_tdata[31:8] : size_r;
    raw       = {in_byte, low_r};
    raw_p1    = {1'b0, raw} + 17'd1;
    rb16      = (16'(w_r) + 16'd7) >> 3;
    need32    = 32'(HEADER_LEN) + ((32'(rb16) * 32'(h_r)) << 2);
    hdr_end   = (phase_eff == PH_HEADER) && (pos_eff >= 3'd5);
    hdr_fail  = bad_eff || (32'(size_eff) < need32);
    col_p1_16 = 16'(col_r) + 16'd1;
    pix_act   = (phase_eff == PH_PIXELS) && (16'(col_r) < rb16);
    pix_store = pix_act && (plane_r != 2'd3);
    pix_emit  = pix_act && (plane_r == 2'd3);
    col_wrap  = col_p1_16 >= rb16;
    row_p1_16 = 16'(row_r) + 16'd1;
    row_end   = row_p1_16 >= 16'(h_r);
    left16    = 16'(w_r) - {13'(col_r), 3'b000};
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_xfer) begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_HEADER: begin
          if (hdr_end) phase_nxt = hdr_fail ? PH_DONE : PH_PIXELS;
        end
        PH_PIXELS: begin
          if (!pix_act) phase_nxt = PH_DONE;
          else if (col_wrap && plane_r == 2'd3 && row_end) phase_nxt = PH_DONE;
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    pos_nxt    = pos_r;
    low_nxt    = low_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    size_nxt   = size_r;
    row_nxt    = row_r;
    plane_nxt  = plane_r;
    col_nxt    = col_r;
    bad_nxt    = bad_r;
    w_ext      = 32'(w_r);
    h_ext      = 32'(h_r);

    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    wout_nxt      = wout_r;
    hout_nxt      = hout_r;
    last_nxt      = last_r;

    if (in_xfer) begin
      // file start clears the header state
      if (sof) begin
        low_nxt  = '0;
        w_nxt    = '0;
        h_nxt    = '0;
        bad_nxt  = 1'b0;
        size_nxt = in_tdata[31:8];
      end
      if (phase_eff == PH_HEADER) begin
        pos_nxt = pos_eff + 3'd1;
        case (pos_eff)
          3'd0, 3'd2: low_nxt = in_byte;
          3'd1: begin
            if (raw >= 16'(MAX_WIDTH)) begin
              bad_nxt = 1'b1;
              w_nxt   = '0;
            end else begin
              w_nxt = raw_p1[W_W-1:0];
            end
          end
          3'd3: begin
            if (raw >= 16'(MAX_HEIGHT)) begin
              bad_nxt = 1'b1;
              h_nxt   = '0;
            end else begin
              h_nxt = raw_p1[H_W-1:0];
            end
          end
          default: ;
        endcase
        if (hdr_end) begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          last_nxt      = 1'b0;
          if (hdr_fail) begin
            kind_nxt = KIND_ERROR;
            wout_nxt = '0;
            hout_nxt = '0;
          end else begin
            kind_nxt  = KIND_DIMS;
            wout_nxt  = w_ext[IMG_W_W-1:0];
            hout_nxt  = h_ext[IMG_H_W-1:0];
            row_nxt   = '0;
            plane_nxt = '0;
            col_nxt   = '0;
          end
        end
      end else if (pix_act) begin
        if (pix_emit) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_PIXELS;
          count_nxt     = (left16 < 16'd8) ? left16[COUNT_W-1:0] : 4'd8;
          wout_nxt      = '0;
          hout_nxt      = '0;
          last_nxt      = row_end && (col_p1_16 == rb16);
        end
        // column, plane and row advance
        if (col_wrap) begin
          col_nxt = '0;
          if (plane_r == 2'd3) begin
            plane_nxt = '0;
            row_nxt   = row_p1_16[H_W-1:0];
          end else begin
            plane_nxt = plane_r + 2'd1;
          end
        end else begin
          col_nxt = col_p1_16[RB_AW-1:0];
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      low_r       <= '0;
      w_r         <= '0;
      h_r         <= '0;
      size_r      <= '0;
      row_r       <= '0;
      plane_r     <= '0;
      col_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      low_r       <= low_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      size_r      <= size_nxt;
      row_r       <= row_nxt;
      plane_r     <= plane_nxt;
      col_r       <= col_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    count_r <= count_nxt;
    wout_r  <= wout_nxt;
    hout_r  <= hout_nxt;
    last_r  <= last_nxt;
  end

  // row buffer writes
  always_ff @(posedge clk) begin
    if (in_xfer && pix_store && plane_r == 2'd0) blue_mem[col_r] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && pix_store && plane_r == 2'd1) green_mem[col_r] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && pix_store && plane_r == 2'd2) red_mem[col_r] <= in_byte;
  end

  // row buffer reads and intensity capture on an intensity byte
  always_ff @(posedge clk) begin
    if (in_xfer && pix_emit) begin
      planes_r.intens <= in_byte;
      planes_r.blue   <= blue_mem[col_r];
      planes_r.green  <= green_mem[col_r];
      planes_r.red    <= red_mem[col_r];
    end
  end

  logic [GROUP_W-1:0] group;

  picn_expand u_expand (
    .planes (planes_r),
    .count  (count_r),
    .group  (group)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, hout_r, wout_r, count_r, group};

endmodule

[rtl/picn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picn_checker
// Port-level checks on the result stream of the planar decoder.
// ----------------------------------------------------------------------------
module picn_checker
  import picn_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [OUT_TDATA_W-1:0]  out_tdata,
  input logic [KIND_W-1:0]       out_tuser,
  input logic                    out_tlast
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // pixel groups carry 1 to 8 pixels and no dimensions
  a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PIXELS |->
      out_tdata[35:32] != 4'd0 && out_tdata[35:32] <= 4'd8 && out_tdata[54:36] == '0)
    else $error("bad pixel group");

  // header results carry no pixels and never end the image
  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PIXELS |->
      !out_tlast && out_tdata[35:0] == '0)
    else $error("header result carries pixel data");

  // accepted dimensions are never zero
  a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DIMS |->
      out_tdata[45:36] != '0 && out_tdata[54:46] != '0)
    else $error("zero dimension accepted");

endmodule

bind planar_icn_to_pixel_index_top picn_checker u_picn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the planar image to pixel index decoder.
// ----------------------------------------------------------------------------
// Files are streamed in one byte per transfer. These include well-formed
// images with random plane content, truncated files, trailing bytes, bad
// headers and loose noise. A decoder model kept in this bench tracks the
// header parse, the row plane buffers and the row/column position. It
// queues one expected result per byte that yields one. Every result
// transfer is checked field by field against the oldest queued result.
// Both sides idle or stall at random, except during a quiet stretch and
// the final part of the run.
// ----------------------------------------------------------------------------
module tb;
  import picn_pkg::*;

  localparam int STORE_COLS  = (MAX_WIDTH_DEF + 7) / 8;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  group;
    logic [3:0]   count;
    logic [9:0]   width;
    logic [8:0]   height;
    logic         last;
  } icn_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [31:0]            in_tdata;   // [7:0] data_byte, [31:8] file_size
  logic                   in_tuser;   // [0] start_of_file
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] pixel_group, [35:32] pixel_count,
                                      // [45:36] image_width, [54:46] image_height
  logic [KIND_W-1:0]      out_tuser;  // [1:0] result_kind
  logic                   out_tlast;  // last_of_image

  // decoder model state
  parse_phase_t phase     = PH_HEADER;
  logic [2:0]   hdr_pos   = '0;
  logic [7:0]   lo_hold   = '0;
  logic [9:0]   img_w     = '0;
  logic [8:0]   img_h     = '0;
  logic [23:0]  size_hold = '0;
  logic [8:0]   row_idx   = '0;
  logic [1:0]   plane_idx = '0;
  logic [6:0]   col_idx   = '0;
  bit           hdr_bad   = 1'b0;
  logic [7:0]   plane_buf [0:3*STORE_COLS-1];

  icn_result_t  pending_q[$];
  int           fails       = 0;
  int           quiet_count = 0;
  int           items_sent  = 0;
  bit           in_idle_en  = 1'b1;
  bit           out_stall_en = 1'b1;

  planar_icn_to_pixel_index_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // model one accepted byte, queue the result it causes
  task automatic decode_byte(input logic [7:0] b, input logic sof, input logic [23:0] sz);
    icn_result_t r;
    bit          has;
    int          raw;
    int          rb;
    int          need;
    int          left;
    int          cnt;
    logic [2:0]  pos;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    has = 1'b0;
    r   = '0;
    if (sof) begin
      phase     = PH_HEADER;
      hdr_pos   = '0;
      lo_hold   = '0;
      img_w     = '0;
      img_h     = '0;
      hdr_bad   = 1'b0;
      size_hold = sz;
    end
    rb = (int'(img_w) + 7) >> 3;
    case (phase)
      PH_HEADER: begin
        pos     = hdr_pos;
        hdr_pos = hdr_pos + 3'd1;
        raw     = int'({b, lo_hold});
        if (pos == 3'd0 || pos == 3'd2) begin
          lo_hold = b;
        end else if (pos == 3'd1) begin
          if (raw >= MAX_WIDTH_DEF) begin
            hdr_bad = 1'b1;
            img_w   = '0;
          end else begin
            img_w = 10'(raw + 1);
          end
        end else if (pos == 3'd3) begin
          if (raw >= MAX_HEIGHT_DEF) begin
            hdr_bad = 1'b1;
            img_h   = '0;
          end else begin
            img_h = 9'(raw + 1);
          end
        end else if (pos >= 3'd5) begin
          need = HEADER_LEN + rb * 4 * int'(img_h);
          has  = 1'b1;
          if (hdr_bad || int'(size_hold) < need) begin
            phase  = PH_DONE;
            r.kind = KIND_ERROR;
          end else begin
            phase     = PH_PIXELS;
            row_idx   = '0;
            plane_idx = '0;
            col_idx   = '0;
            r.kind    = KIND_DIMS;
            r.width   = img_w;
            r.height  = img_h;
          end
        end
      end
      PH_PIXELS: begin
        if (int'(col_idx) >= rb) begin
          phase = PH_DONE;
        end else begin
          if (plane_idx < 2'd3) begin
            plane_buf[int'(plane_idx) * STORE_COLS + int'(col_idx)] = b;
          end else begin
            blue  = plane_buf[int'(col_idx)];
            green = plane_buf[STORE_COLS + int'(col_idx)];
            red   = plane_buf[2 * STORE_COLS + int'(col_idx)];
            left  = int'(img_w) - int'(col_idx) * 8;
            cnt   = (left < 8) ? left : 8;
            for (int k = 0; k < cnt; k++) begin
              r.group[31-4*k -: 4] = {b[7-k], red[7-k], green[7-k], blue[7-k]};
            end
            r.kind  = KIND_PIXELS;
            r.count = 4'(cnt);
            r.last  = (int'(row_idx) + 1 >= int'(img_h)) && (int'(col_idx) + 1 == rb);
            has     = 1'b1;
          end
          col_idx = col_idx + 7'd1;
          if (int'(col_idx) >= rb) begin
            col_idx = '0;
            if (plane_idx >= 2'd3) begin
              plane_idx = '0;
              row_idx   = row_idx + 9'd1;
              if (row_idx >= img_h) phase = PH_DONE;
            end else begin
              plane_idx = plane_idx + 2'd1;
            end
          end
        end
      end
      default: ;
    endcase
    if (has) pending_q.push_back(r);
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result();
    icn_result_t e;
    if (pending_q.size() == 0) begin
      $error("result with nothing expected: kind %0d tdata %0h", out_tuser, out_tdata);
      fails++;
    end else begin
      e = pending_q.pop_front();
      if (out_tuser !== e.kind) begin
        $error("result_kind expected %0d actual %0d", e.kind, out_tuser);
        fails++;
      end
      if (out_tdata[31:0] !== e.group) begin
        $error("pixel_group expected %08h actual %08h", e.group, out_tdata[31:0]);
        fails++;
      end
      if (out_tdata[35:32] !== e.count) begin
        $error("pixel_count expected %0d actual %0d", e.count, out_tdata[35:32]);
        fails++;
      end
      if (out_tdata[45:36] !== e.width) begin
        $error("image_width expected %0d actual %0d", e.width, out_tdata[45:36]);
        fails++;
      end
      if (out_tdata[54:46] !== e.height) begin
        $error("image_height expected %0d actual %0d", e.height, out_tdata[54:46]);
        fails++;
      end
      if (out_tlast !== e.last) begin
        $error("last_of_image expected %0d actual %0d", e.last, out_tlast);
        fails++;
      end
    end
  endtask

  // transfer monitor: check results first, then model the accepted byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata[7:0], in_tuser, in_tdata[31:8]);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count + 1 >= QUIET_LIMIT) begin
        $display("planar_icn_to_pixel_index_top test failed");
        $finish;
      end
    end
  end

  // result side backpressure in random bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stall_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // one byte transfer, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic [23:0] sz);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sz, b};
    in_tuser  <= sof;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // stop sending until every queued result has arrived
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // header (raw width-1, raw height-1), then body bytes, then trailing bytes
  task automatic send_image(input logic [15:0] raw_w, input logic [15:0] raw_h,
                            input logic [23:0] sz, input int n_body, input int n_tail);
    send_byte(raw_w[7:0], 1'b1, sz);
    send_byte(raw_w[15:8], 1'b0, 24'($urandom));
    send_byte(raw_h[7:0], 1'b0, 24'($urandom));
    send_byte(raw_h[15:8], 1'b0, 24'($urandom));
    send_byte(8'($urandom), 1'b0, 24'($urandom));
    send_byte(8'($urandom), 1'b0, 24'($urandom));
    repeat (n_body) send_byte(8'($urandom), 1'b0, 24'($urandom));
    repeat (n_tail) send_byte(8'($urandom), 1'b0, 24'($urandom));
    items_sent += HEADER_LEN + n_body;
  endtask

  // bytes with no file start after reset form a header with size zero
  task automatic test_headerless();
    repeat (HEADER_LEN) send_byte(8'($urandom), 1'b0, 24'($urandom));
    items_sent += HEADER_LEN;
  endtask

  // largest image with exactly enough size, then cut short by the next file
  task automatic test_extreme_dims();
    send_image(16'(MAX_WIDTH_DEF - 1), 16'(MAX_HEIGHT_DEF - 1),
               24'(HEADER_LEN + STORE_COLS * 4 * MAX_HEIGHT_DEF), 0, 0);
  endtask

  // 1x1 image, saturated size, extreme plane bytes, one trailing byte
  task automatic test_single_pixel();
    send_byte(8'h00, 1'b1, 24'hFF_FFFF);
    repeat (5) send_byte(8'h00, 1'b0, 24'h00_0000);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFF);
    send_byte(8'h00, 1'b0, 24'h00_0000);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFF);
    send_byte(8'h80, 1'b0, 24'h00_0000);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFF);
    items_sent += 10;
  endtask

  // mostly well-formed files with random content, plus bad headers and noise
  task automatic test_random_files();
    int          sel;
    int          w;
    int          h;
    int          rb;
    int          need;
    int          n_body;
    int          n_tail;
    logic [23:0] sz;
    logic [15:0] raw_w;
    logic [15:0] raw_h;
    while (items_sent < ITEM_TARGET) begin
      in_idle_en   = (items_sent < 700) || (items_sent >= 1000 && items_sent < 1550);
      out_stall_en = in_idle_en;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        case ($urandom_range(0, 9))
          0: begin
            w = $urandom_range(1, MAX_WIDTH_DEF);
            h = 1;
          end
          1: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 24);
          end
          default: begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 6);
          end
        endcase
        rb   = (w + 7) / 8;
        need = HEADER_LEN + rb * 4 * h;
        case ($urandom_range(0, 9))
          0:       sz = 24'(need - 1);
          1:       sz = 24'hFF_FFFF;
          2:       sz = 24'(need + int'($urandom_range(1, 1000)));
          default: sz = 24'(need);
        endcase
        n_body = rb * 4 * h;
        if ($urandom_range(0, 9) == 0) n_body = int'($urandom_range(0, n_body - 1));
        n_tail = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
        send_image(16'(w - 1), 16'(h - 1), sz, n_body, n_tail);
      end else if (sel < 85) begin
        case ($urandom_range(0, 3))
          0: raw_w = 16'hFFFF;
          1: raw_w = 16'(MAX_WIDTH_DEF);
          2: raw_w = 16'(MAX_WIDTH_DEF - 1);
          default: raw_w = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: raw_h = 16'hFFFF;
          1: raw_h = 16'(MAX_HEIGHT_DEF);
          2: raw_h = 16'($urandom_range(0, 3));
          default: raw_h = 16'($urandom);
        endcase
        send_image(raw_w, raw_h, 24'($urandom), int'($urandom_range(0, 8)), 0);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_byte(8'($urandom), ($urandom_range(0, 5) == 0), 24'($urandom));
        end
      end
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
    in_idle_en   = 1'b0;
    out_stall_en = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_headerless();
    test_extreme_dims();
    test_single_pixel();
    wait_results_drained();
    test_random_files();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fails == 0) begin
      $display("planar_icn_to_pixel_index_top test passed");
    end else begin
      $display("planar_icn_to_pixel_index_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/picn_pkg.sv
rtl/picn_expand.sv
rtl/planar_icn_to_pixel_index_top.sv
rtl/picn_checker.sv
bench/tb.sv
